// File: rtl/qbnm_pkg.sv
package qbnm_pkg;

  localparam int COORD_W    = 32;
  localparam int DIV_W      = 10;
  localparam int SLOT_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int NUM_POINTS = 9;
  localparam int NUM_DIMS   = 3;
  localparam int NUM_CORNERS = 4;
  localparam int MAX_DIVISIONS = 1023;

  // Q2.30 fraction bits; multiplier operand and product widths
  localparam int FRAC_W = 30;
  localparam int OPND_W = COORD_W + 1;
  localparam int PROD_W = 2 * OPND_W;
  localparam int RND_W  = PROD_W - FRAC_W;

  localparam logic signed [COORD_W-1:0] Q30_ONE   = COORD_W'(64'sd1 <<< FRAC_W);
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_DIV_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_Y = 1'b1;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_GEN  = 1'b1;

  typedef logic [1:0] op_kind_t;
  localparam op_kind_t KIND_SHAPE_X = 2'd0;
  localparam op_kind_t KIND_SHAPE_Y = 2'd1;
  localparam op_kind_t KIND_WEIGHT  = 2'd2;
  localparam op_kind_t KIND_MAC     = 2'd3;

  typedef logic [1:0] dim_t;
  localparam dim_t DIM_X = 2'd0;
  localparam dim_t DIM_Y = 2'd1;
  localparam dim_t DIM_Z = 2'd2;

  // tag that travels with each product through the multiplier pipeline
  typedef struct packed {
    logic              vld;
    op_kind_t          kind;
    logic [SLOT_W-1:0] idx;
    dim_t              dim;
  } op_tag_t;

  // clamp a division count to 1..MAX_DIVISIONS
  function automatic logic [DIV_W-1:0] eff_div(input logic [DIV_W-1:0] d);
    logic [DIV_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DIV_W'(1);
    end else if (32'(d) > 32'(MAX_DIVISIONS)) begin
      r = DIV_W'(MAX_DIVISIONS);
    end
    return r;
  endfunction

  // which 1-D shape value along xi feeds control point k
  function automatic logic [1:0] shape_col(input logic [SLOT_W-1:0] k);
    logic [1:0] r;
    unique case (k)
      4'd0, 4'd3, 4'd7: r = 2'd0;
      4'd4, 4'd6, 4'd8: r = 2'd1;
      4'd1, 4'd2, 4'd5: r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  // which 1-D shape value along eta feeds control point k
  function automatic logic [1:0] shape_row(input logic [SLOT_W-1:0] k);
    logic [1:0] r;
    unique case (k)
      4'd0, 4'd1, 4'd4: r = 2'd0;
      4'd5, 4'd7, 4'd8: r = 2'd1;
      4'd2, 4'd3, 4'd6: r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/quad9_block_node_mapper_unit.sv
// Channel  Dir  Fields (ports carry the channel prefix)                    Handshake
// in       in   req_type point_index point_defined coord_x/y/z grid_i/j  in_valid / in_ready
// out      out  node_x node_y node_z                                     out_valid / out_ready
// cfg      in   index data                                               cfg_valid / cfg_ready
//
// A load word only stores its point and defined flag; a generate word with an undefined corner
// is dropped. Any other generate word passes through the shared divider (two 32-bit quotients
// at 4 bits a cycle), the shared 33x33 multiplier (shape values, weights, nine-term sums)
// and final rounding, then loads the output register; no new word is taken meanwhile.
// Synchronous reset (rst_n low) clears the defined flags and sets both division counts to 1.
// A held result keeps the next generate word in its final step until out_ready frees it.
module quad9_block_node_mapper_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_req_type,
  input  logic [qbnm_pkg::SLOT_W-1:0]          in_point_index,
  input  logic                                 in_point_defined,
  input  logic signed [qbnm_pkg::COORD_W-1:0]  in_coord_x,
  input  logic signed [qbnm_pkg::COORD_W-1:0]  in_coord_y,
  input  logic signed [qbnm_pkg::COORD_W-1:0]  in_coord_z,
  input  logic [qbnm_pkg::DIV_W-1:0]           in_grid_i,
  input  logic [qbnm_pkg::DIV_W-1:0]           in_grid_j,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [qbnm_pkg::COORD_W-1:0]  out_node_x,
  output logic signed [qbnm_pkg::COORD_W-1:0]  out_node_y,
  output logic signed [qbnm_pkg::COORD_W-1:0]  out_node_z,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [qbnm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qbnm_pkg::DIV_W-1:0]           cfg_data
);
  import qbnm_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV_X = 3'd1;
  localparam logic [2:0] ST_DIV_Y = 3'd2;
  localparam logic [2:0] ST_MAC   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam int DIV_STEP   = 4;
  localparam int DIV_CYCLES = COORD_W / DIV_STEP;
  localparam int CNT_W      = $clog2(DIV_CYCLES);
  localparam int REM_W      = DIV_W + 1;
  localparam int MID_W      = COORD_W + 1;
  localparam int CEN_W      = COORD_W + 2;

  localparam logic [SLOT_W-1:0] SHAPE_LAST = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(NUM_POINTS - 1);
  localparam logic [SLOT_W-1:0] SLOT_CEN   = SLOT_W'(NUM_POINTS - 1);
  localparam logic [SLOT_W-1:0] SLOT_FIRST_MID = SLOT_W'(NUM_CORNERS);
  localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(DIV_CYCLES - 1);

  localparam logic signed [PROD_W-1:0] HALF_29 = PROD_W'(1) << (FRAC_W - 1);
  localparam logic signed [PROD_W-1:0] HALF_30 = PROD_W'(1) << FRAC_W;

  logic [2:0] state_r, state_nxt;

  logic [DIV_W-1:0] div_x_r, div_y_r;
  logic [NUM_POINTS-1:0] def_r;
  logic [NUM_DIMS-1:0][COORD_W-1:0] coord_r [NUM_POINTS];

  logic in_fire, gen_go;
  logic [DIV_W-1:0] nx_eff, ny_eff, ix_clamp, iy_clamp;
  logic [DIV_W-1:0] grid_y_r, ny_eff_r;

  // divider
  logic [CNT_W-1:0]   cnt_r;
  logic [REM_W-1:0]   rem_r, rem_w;
  logic [COORD_W-1:0] qd_r, qd_w;
  logic [REM_W-1:0]   dv_r;
  logic [REM_W:0]     trial, diff;
  logic signed [COORD_W-1:0] nat_w;
  logic signed [COORD_W-1:0] nat_x_r, nat_y_r;
  logic div_last;

  // multiplier sequencer
  logic       sel_on_r;
  op_kind_t   sel_kind_r;
  logic [SLOT_W-1:0] sel_idx_r;
  dim_t       sel_dim_r;
  op_tag_t    sel_tag, op_tag_r, prod_tag_r;

  logic signed [COORD_W-1:0] nx_r [3];
  logic signed [COORD_W-1:0] ny_r [3];
  logic signed [COORD_W-1:0] w_r [NUM_POINTS];
  logic signed [COORD_W-1:0] corner_r [NUM_CORNERS];

  logic signed [COORD_W-1:0] xv, rd, mid_a, mid_b, mid_v, cen_v, pt_v;
  logic signed [MID_W-1:0]   mid_sum;
  logic signed [CEN_W-1:0]   cen_sum;
  logic signed [OPND_W-1:0]  opa_nxt, opb_nxt, op_a_r, op_b_r;
  logic signed [PROD_W-1:0]  prod_r, sum29, sum30, acc_r, acc_sum, fin_r, fin_sum;
  logic signed [COORD_W-1:0] shape_v;
  logic signed [RND_W-1:0]   rr;
  logic signed [COORD_W-1:0] sat_v;
  logic       fin_vld_r;
  dim_t       fin_dim_r;
  logic signed [COORD_W-1:0] res_r [NUM_DIMS];

  logic out_valid_r;
  logic signed [COORD_W-1:0] out_node_x_r, out_node_y_r, out_node_z_r;
  logic out_load;

  assign in_ready   = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_node_x = out_node_x_r;
  assign out_node_y = out_node_y_r;
  assign out_node_z = out_node_z_r;

  assign in_fire  = in_valid && in_ready;
  assign gen_go   = in_fire && (in_req_type == REQ_GEN) && (&def_r[NUM_CORNERS-1:0]);
  assign nx_eff   = eff_div(div_x_r);
  assign ny_eff   = eff_div(div_y_r);
  assign ix_clamp = (in_grid_i > nx_eff) ? nx_eff : in_grid_i;
  assign iy_clamp = (in_grid_j > ny_eff) ? ny_eff : in_grid_j;
  assign div_last = (cnt_r == CNT_LAST);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (gen_go) state_nxt = ST_DIV_X;
      ST_DIV_X: if (div_last) state_nxt = ST_DIV_Y;
      ST_DIV_Y: if (div_last) state_nxt = ST_MAC;
      ST_MAC:   if (fin_vld_r && (fin_dim_r == DIM_Z)) state_nxt = ST_OUT;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_x_r     <= DIV_W'(1);
      div_y_r     <= DIV_W'(1);
      def_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DIV_X: div_x_r <= cfg_data;
          REG_DIV_Y: div_y_r <= cfg_data;
          default:   ;
        endcase
      end
      if (in_fire && (in_req_type == REQ_LOAD) && (in_point_index <= SLOT_LAST)) begin
        def_r[in_point_index] <= in_point_defined;
      end
      if ((state_r == ST_DIV_X) || (state_r == ST_DIV_Y)) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else begin
        cnt_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_req_type == REQ_LOAD) && (in_point_index <= SLOT_LAST)) begin
      coord_r[in_point_index] <= {in_coord_z, in_coord_y, in_coord_x};
    end
  end

  // ---------------------------------------------------------------- divider
  // quotient of (idx*2^32 + n) / 2n; idx < 2n, so only the low 32 quotient bits live
  always_comb begin
    rem_w = rem_r;
    qd_w  = qd_r;
    trial = '0;
    diff  = '0;
    for (int b = 0; b < DIV_STEP; b++) begin
      trial = {rem_w, qd_w[COORD_W-1]};
      diff  = trial - {1'b0, dv_r};
      if (trial >= {1'b0, dv_r}) begin
        rem_w = diff[REM_W-1:0];
        qd_w  = {qd_w[COORD_W-2:0], 1'b1};
      end else begin
        rem_w = trial[REM_W-1:0];
        qd_w  = {qd_w[COORD_W-2:0], 1'b0};
      end
    end
    nat_w = $signed(qd_w - $unsigned(Q30_ONE));
  end

  always_ff @(posedge clk) begin
    if (gen_go) begin
      rem_r    <= {1'b0, ix_clamp};
      qd_r     <= COORD_W'(nx_eff);
      dv_r     <= {nx_eff, 1'b0};
      grid_y_r <= iy_clamp;
      ny_eff_r <= ny_eff;
    end else if ((state_r == ST_DIV_X) && div_last) begin
      nat_x_r <= nat_w;
      rem_r   <= {1'b0, grid_y_r};
      qd_r    <= COORD_W'(ny_eff_r);
      dv_r    <= {ny_eff_r, 1'b0};
    end else if ((state_r == ST_DIV_X) || (state_r == ST_DIV_Y)) begin
      rem_r <= rem_w;
      qd_r  <= qd_w;
      if (div_last) begin
        nat_y_r <= nat_w;
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_on_r   <= 1'b0;
      sel_kind_r <= KIND_SHAPE_X;
      sel_idx_r  <= '0;
      sel_dim_r  <= DIM_X;
    end else if ((state_r == ST_DIV_Y) && div_last) begin
      sel_on_r   <= 1'b1;
      sel_kind_r <= KIND_SHAPE_X;
      sel_idx_r  <= '0;
      sel_dim_r  <= DIM_X;
    end else if (sel_on_r) begin
      unique case (sel_kind_r)
        KIND_SHAPE_X: begin
          if (sel_idx_r == SHAPE_LAST) begin
            sel_kind_r <= KIND_SHAPE_Y;
            sel_idx_r  <= '0;
          end else begin
            sel_idx_r <= sel_idx_r + SLOT_W'(1);
          end
        end
        KIND_SHAPE_Y: begin
          if (sel_idx_r == SHAPE_LAST) begin
            sel_kind_r <= KIND_WEIGHT;
            sel_idx_r  <= '0;
          end else begin
            sel_idx_r <= sel_idx_r + SLOT_W'(1);
          end
        end
        KIND_WEIGHT: begin
          if (sel_idx_r == SLOT_LAST) begin
            sel_kind_r <= KIND_MAC;
            sel_idx_r  <= '0;
            sel_dim_r  <= DIM_X;
          end else begin
            sel_idx_r <= sel_idx_r + SLOT_W'(1);
          end
        end
        KIND_MAC: begin
          if (sel_idx_r == SLOT_LAST) begin
            sel_idx_r <= '0;
            if (sel_dim_r == DIM_Z) begin
              sel_on_r <= 1'b0;
            end else begin
              sel_dim_r <= sel_dim_r + 2'd1;
            end
          end else begin
            sel_idx_r <= sel_idx_r + SLOT_W'(1);
          end
        end
        default: sel_on_r <= 1'b0;
      endcase
    end
  end

  assign sel_tag = '{vld: sel_on_r, kind: sel_kind_r, idx: sel_idx_r, dim: sel_dim_r};

  // operand select: natural coordinate, shape values, or weight and control or derived point
  always_comb begin
    xv = (sel_kind_r == KIND_SHAPE_X) ? nat_x_r : nat_y_r;
    rd = $signed(coord_r[sel_idx_r][sel_dim_r]);

    unique case (sel_idx_r)
      4'd4:    begin mid_a = corner_r[0]; mid_b = corner_r[1]; end
      4'd5:    begin mid_a = corner_r[1]; mid_b = corner_r[2]; end
      4'd6:    begin mid_a = corner_r[2]; mid_b = corner_r[3]; end
      default: begin mid_a = corner_r[3]; mid_b = corner_r[0]; end
    endcase
    mid_sum = MID_W'(mid_a) + MID_W'(mid_b) + MID_W'(1);
    mid_v   = mid_sum[MID_W-1:1];
    cen_sum = CEN_W'(corner_r[0]) + CEN_W'(corner_r[1]) + CEN_W'(corner_r[2])
            + CEN_W'(corner_r[3]) + CEN_W'(2);
    cen_v   = cen_sum[CEN_W-1:2];

    priority if ((sel_idx_r < SLOT_FIRST_MID) || def_r[sel_idx_r]) begin
      pt_v = rd;
    end else if (sel_idx_r == SLOT_CEN) begin
      pt_v = cen_v;
    end else begin
      pt_v = mid_v;
    end

    unique case (sel_kind_r)
      KIND_SHAPE_X, KIND_SHAPE_Y: begin
        opa_nxt = OPND_W'(xv);
        priority if (sel_idx_r == SLOT_W'(0)) begin
          opb_nxt = OPND_W'(xv) - OPND_W'(Q30_ONE);
        end else if (sel_idx_r == SLOT_W'(1)) begin
          opb_nxt = OPND_W'(xv);
        end else begin
          opb_nxt = OPND_W'(xv) + OPND_W'(Q30_ONE);
        end
      end
      KIND_WEIGHT: begin
        opa_nxt = OPND_W'(nx_r[shape_col(sel_idx_r)]);
        opb_nxt = OPND_W'(ny_r[shape_row(sel_idx_r)]);
      end
      default: begin
        opa_nxt = OPND_W'(w_r[sel_idx_r]);
        opb_nxt = OPND_W'(pt_v);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_tag_r   <= '0;
      prod_tag_r <= '0;
      fin_vld_r  <= 1'b0;
    end else begin
      op_tag_r   <= sel_tag;
      prod_tag_r <= op_tag_r;
      fin_vld_r  <= prod_tag_r.vld && (prod_tag_r.kind == KIND_MAC)
                    && (prod_tag_r.idx == SLOT_LAST);
    end
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    sum29   = prod_r + HALF_29;
    sum30   = prod_r + HALF_30;
    acc_sum = acc_r + prod_r;
    if (prod_tag_r.idx == SLOT_W'(1)) begin
      shape_v = Q30_ONE - $signed(sum29[FRAC_W+COORD_W-1:FRAC_W]);
    end else begin
      shape_v = $signed(sum30[FRAC_W+COORD_W:FRAC_W+1]);
    end
    fin_sum = fin_r + HALF_29;
    rr      = fin_sum[PROD_W-1:FRAC_W];
    // saturate when the bits above the sign do not all match it
    if ((&rr[RND_W-1:COORD_W-1]) || !(|rr[RND_W-1:COORD_W-1])) begin
      sat_v = rr[COORD_W-1:0];
    end else if (rr[RND_W-1]) begin
      sat_v = COORD_MIN;
    end else begin
      sat_v = COORD_MAX;
    end
  end

  always_ff @(posedge clk) begin
    op_a_r <= opa_nxt;
    op_b_r <= opb_nxt;
    prod_r <= op_a_r * op_b_r;

    if (sel_on_r && (sel_kind_r == KIND_MAC) && (sel_idx_r < SLOT_FIRST_MID)) begin
      corner_r[sel_idx_r[1:0]] <= rd;
    end

    if (prod_tag_r.vld) begin
      unique case (prod_tag_r.kind)
        KIND_SHAPE_X: nx_r[prod_tag_r.idx[1:0]] <= shape_v;
        KIND_SHAPE_Y: ny_r[prod_tag_r.idx[1:0]] <= shape_v;
        KIND_WEIGHT:  w_r[prod_tag_r.idx] <= $signed(sum29[FRAC_W+COORD_W-1:FRAC_W]);
        default: begin
          if (prod_tag_r.idx == '0) begin
            acc_r <= prod_r;
          end else begin
            acc_r <= acc_sum;
          end
          if (prod_tag_r.idx == SLOT_LAST) begin
            fin_r     <= acc_sum;
            fin_dim_r <= prod_tag_r.dim;
          end
        end
      endcase
    end

    if (fin_vld_r) begin
      res_r[fin_dim_r] <= sat_v;
    end

    if (out_load) begin
      out_node_x_r <= res_r[DIM_X];
      out_node_y_r <= res_r[DIM_Y];
      out_node_z_r <= res_r[DIM_Z];
    end
  end

endmodule
